// ===== rtl/huffman_code_builder_top_macros.svh =====
// Assertion helpers for the checks in the top-level design file.
`ifndef HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HCB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HCB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define HCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;

  localparam int TAG_W   = 8;
  localparam int FREQ_W  = 16;
  localparam int LEN_W   = 5;
  localparam int CODE_W  = 31;
  localparam logic [LEN_W-1:0] MAX_LEN = 5'd31;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SU_STEP,
    S_SU_CMP,
    S_BUILD,
    S_POP_RD0,
    S_POP_RDL,
    S_POP_LAST,
    S_SD_START,
    S_SD_GETL,
    S_SD_CMP,
    S_MERGE,
    S_WALK_RD,
    S_WALK_ROOT,
    S_W_NODE,
    S_W_KIDS,
    S_W_TAG,
    S_W_POP,
    S_FINISH
  } hcb_state_t;

  typedef struct packed {
    logic load;
    logic su_step;
    logic su_cmp;
    logic pop_rd0;
    logic pop_rdl;
    logic pop_last;
    logic sd_start;
    logic sd_getl;
    logic sd_cmp;
    logic sel_b;
    logic merge;
    logic walk_rd;
    logic walk_root;
    logic w_node;
    logic w_kids;
    logic w_tag;
    logic w_pop;
    logic finish;
  } hcb_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic su_swap;
    logic has_l;
    logic sd_swap;
    logic cnt_gt1;
    logic full;
    logic is_leaf;
    logic sp_zero;
    logic out_free;
  } hcb_stat_t;

endpackage

// ===== rtl/hcb_ram.sv =====
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hcb_ctrl.sv =====
module hcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final_symbol,
  output logic              in_stall,
  input  hcb_pkg::hcb_stat_t stat,
  output hcb_pkg::hcb_cmd_t  cmd
);

  hcb_pkg::hcb_state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  logic sel_b_r, sel_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcb_pkg::S_IDLE;
      fin_r   <= 1'b0;
      sel_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      sel_b_r <= sel_b_nxt;
    end
  end

  assign in_stall = (state_r != hcb_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    sel_b_nxt = sel_b_r;
    cmd       = '0;
    cmd.sel_b = sel_b_r;
    case (state_r)
      hcb_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          fin_nxt  = in_final_symbol;
          // A symbol that finds the heap full is dropped.
          if (stat.full) begin
            state_nxt = in_final_symbol ? hcb_pkg::S_BUILD : hcb_pkg::S_IDLE;
          end else begin
            state_nxt = hcb_pkg::S_SU_STEP;
          end
        end
      end
      hcb_pkg::S_SU_STEP: begin
        cmd.su_step = 1'b1;
        if (stat.pos_zero) begin
          state_nxt = fin_r ? hcb_pkg::S_BUILD : hcb_pkg::S_IDLE;
        end else begin
          state_nxt = hcb_pkg::S_SU_CMP;
        end
      end
      hcb_pkg::S_SU_CMP: begin
        cmd.su_cmp = 1'b1;
        if (stat.su_swap) begin
          state_nxt = hcb_pkg::S_SU_STEP;
        end else begin
          state_nxt = fin_r ? hcb_pkg::S_BUILD : hcb_pkg::S_IDLE;
        end
      end
      hcb_pkg::S_BUILD: begin
        sel_b_nxt = 1'b0;
        state_nxt = stat.cnt_gt1 ? hcb_pkg::S_POP_RD0 : hcb_pkg::S_WALK_RD;
      end
      hcb_pkg::S_POP_RD0: begin
        cmd.pop_rd0 = 1'b1;
        state_nxt   = hcb_pkg::S_POP_RDL;
      end
      hcb_pkg::S_POP_RDL: begin
        cmd.pop_rdl = 1'b1;
        state_nxt   = hcb_pkg::S_POP_LAST;
      end
      hcb_pkg::S_POP_LAST: begin
        cmd.pop_last = 1'b1;
        state_nxt    = hcb_pkg::S_SD_START;
      end
      hcb_pkg::S_SD_START: begin
        cmd.sd_start = 1'b1;
        if (stat.has_l) begin
          state_nxt = hcb_pkg::S_SD_GETL;
        end else if (sel_b_r) begin
          state_nxt = hcb_pkg::S_MERGE;
        end else begin
          sel_b_nxt = 1'b1;
          state_nxt = hcb_pkg::S_POP_RD0;
        end
      end
      hcb_pkg::S_SD_GETL: begin
        cmd.sd_getl = 1'b1;
        state_nxt   = hcb_pkg::S_SD_CMP;
      end
      hcb_pkg::S_SD_CMP: begin
        cmd.sd_cmp = 1'b1;
        if (stat.sd_swap) begin
          state_nxt = hcb_pkg::S_SD_START;
        end else if (sel_b_r) begin
          state_nxt = hcb_pkg::S_MERGE;
        end else begin
          sel_b_nxt = 1'b1;
          state_nxt = hcb_pkg::S_POP_RD0;
        end
      end
      hcb_pkg::S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = hcb_pkg::S_SU_STEP;
      end
      hcb_pkg::S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = hcb_pkg::S_WALK_ROOT;
      end
      hcb_pkg::S_WALK_ROOT: begin
        cmd.walk_root = 1'b1;
        state_nxt     = hcb_pkg::S_W_NODE;
      end
      hcb_pkg::S_W_NODE: begin
        cmd.w_node = 1'b1;
        state_nxt  = stat.is_leaf ? hcb_pkg::S_W_TAG : hcb_pkg::S_W_KIDS;
      end
      hcb_pkg::S_W_KIDS: begin
        cmd.w_kids = 1'b1;
        state_nxt  = hcb_pkg::S_W_NODE;
      end
      hcb_pkg::S_W_TAG: begin
        if (stat.out_free) begin
          cmd.w_tag = 1'b1;
          state_nxt = stat.sp_zero ? hcb_pkg::S_FINISH : hcb_pkg::S_W_POP;
        end
      end
      hcb_pkg::S_W_POP: begin
        cmd.w_pop = 1'b1;
        state_nxt = hcb_pkg::S_W_NODE;
      end
      hcb_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        fin_nxt    = 1'b0;
        state_nxt  = hcb_pkg::S_IDLE;
      end
      default: begin
        state_nxt = hcb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hcb_datapath.sv =====
module hcb_datapath #(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hcb_pkg::hcb_cmd_t                cmd,
  output hcb_pkg::hcb_stat_t               stat,
  input  logic [hcb_pkg::TAG_W-1:0]        in_symbol_tag,
  input  logic [hcb_pkg::FREQ_W-1:0]       in_frequency,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [hcb_pkg::TAG_W-1:0]        out_tag,
  output logic [hcb_pkg::LEN_W-1:0]        out_code_length,
  output logic [hcb_pkg::CODE_W-1:0]       out_code_bits,
  output logic                             out_last_code
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int NW = $clog2(2 * MAX_SYMBOLS);
  localparam int WW = hcb_pkg::FREQ_W + AW;
  localparam int EW = NW + WW;
  localparam int XW = AW + 2;
  localparam int LW = hcb_pkg::LEN_W;
  localparam int BW = hcb_pkg::CODE_W;
  localparam int SW = NW + LW + BW;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [AW-1:0] pos_r, pos_nxt;
  logic [NW-1:0] cur_id_r, cur_id_nxt, a_id_r, a_id_nxt, b_id_r, b_id_nxt;
  logic [NW-1:0] l_id_r, l_id_nxt, w_id_r, w_id_nxt;
  logic [WW-1:0] cur_w_r, cur_w_nxt, a_w_r, a_w_nxt, b_w_r, b_w_nxt, l_w_r, l_w_nxt;
  logic [LW-1:0] w_len_r, w_len_nxt, o_len_r, o_len_nxt;
  logic [BW-1:0] w_code_r, w_code_nxt, o_code_r, o_code_nxt;
  logic [hcb_pkg::TAG_W-1:0] o_tag_r, o_tag_nxt;
  logic o_last_r, o_last_nxt;

  logic h_we, h_re;
  logic [AW-1:0] h_wa, h_ra;
  logic [EW-1:0] h_wd, h_rd;
  logic t_we, t_re;
  logic [AW-1:0] t_wa, t_ra;
  logic [hcb_pkg::TAG_W-1:0] t_wd, t_rd;
  logic c_we, c_re;
  logic [AW-1:0] c_wa, c_ra;
  logic [2*NW-1:0] c_wd, c_rd;
  logic s_we, s_re;
  logic [CW-1:0] s_wa, s_ra;
  logic [SW-1:0] s_wd, s_rd;

  logic [NW-1:0] h_rd_id, m_id;
  logic [WW-1:0] h_rd_w, m_w;
  logic [AW-1:0] pos_m1, parent, m_idx, w_k;
  logic [XW-1:0] lft_x, rgt_x, cnt_x;
  logic has_l, has_r, take_r;
  logic [CW-1:0] cnt_m1, sp_m1;
  logic [LW-1:0] nl;
  logic [BW-1:0] c0, c1;

  hcb_ram #(.WIDTH(EW), .DEPTH(MAX_SYMBOLS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
    .re(h_re), .raddr(h_ra), .rdata(h_rd)
  );

  hcb_ram #(.WIDTH(hcb_pkg::TAG_W), .DEPTH(MAX_SYMBOLS)) u_tag (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd),
    .re(t_re), .raddr(t_ra), .rdata(t_rd)
  );

  hcb_ram #(.WIDTH(2 * NW), .DEPTH(MAX_SYMBOLS)) u_child (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .re(c_re), .raddr(c_ra), .rdata(c_rd)
  );

  hcb_ram #(.WIDTH(SW), .DEPTH(MAX_SYMBOLS + 1)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
    .re(s_re), .raddr(s_ra), .rdata(s_rd)
  );

  assign h_rd_id = h_rd[EW-1:WW];
  assign h_rd_w  = h_rd[WW-1:0];
  assign pos_m1  = pos_r - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign lft_x   = {1'b0, pos_r, 1'b1};
  assign rgt_x   = lft_x + XW'(1);
  assign cnt_x   = XW'(cnt_r);
  assign has_l   = (lft_x < cnt_x);
  assign has_r   = (rgt_x < cnt_x);
  // Ties between the children go to the left one.
  assign take_r  = has_r && (h_rd_w < l_w_r);
  assign m_id    = take_r ? h_rd_id : l_id_r;
  assign m_w     = take_r ? h_rd_w : l_w_r;
  assign m_idx   = take_r ? rgt_x[AW-1:0] : lft_x[AW-1:0];
  assign cnt_m1  = cnt_r - CW'(1);
  assign sp_m1   = sp_r - CW'(1);
  assign w_k     = AW'(w_id_r - NW'(MAX_SYMBOLS));

  // Past the deepest length the code stops growing.
  assign nl = (w_len_r < hcb_pkg::MAX_LEN) ? (w_len_r + LW'(1)) : w_len_r;
  assign c0 = (w_len_r < hcb_pkg::MAX_LEN) ? {w_code_r[BW-2:0], 1'b0} : w_code_r;
  assign c1 = (w_len_r < hcb_pkg::MAX_LEN) ? {w_code_r[BW-2:0], 1'b1} : w_code_r;

  assign stat.pos_zero = (pos_r == '0);
  assign stat.su_swap  = (cur_w_r < h_rd_w);
  assign stat.has_l    = has_l;
  assign stat.sd_swap  = (cur_w_r > m_w);
  assign stat.cnt_gt1  = (cnt_r > CW'(1));
  assign stat.full     = (cnt_r == CW'(MAX_SYMBOLS));
  assign stat.is_leaf  = (w_id_r < NW'(MAX_SYMBOLS));
  assign stat.sp_zero  = (sp_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;   k_nxt = k_r;   sp_nxt = sp_r;
    out_valid_nxt = out_valid_r;
    pos_nxt = pos_r;
    cur_id_nxt = cur_id_r; cur_w_nxt = cur_w_r;
    a_id_nxt = a_id_r; a_w_nxt = a_w_r; b_id_nxt = b_id_r; b_w_nxt = b_w_r;
    l_id_nxt = l_id_r; l_w_nxt = l_w_r;
    w_id_nxt = w_id_r; w_len_nxt = w_len_r; w_code_nxt = w_code_r;
    o_tag_nxt = o_tag_r; o_len_nxt = o_len_r; o_code_nxt = o_code_r;
    o_last_nxt = o_last_r;
    h_we = 1'b0; h_wa = pos_r; h_wd = {cur_id_r, cur_w_r}; h_re = 1'b0; h_ra = '0;
    t_we = 1'b0; t_wa = cnt_r[AW-1:0]; t_wd = in_symbol_tag; t_re = 1'b0;
    t_ra = w_id_r[AW-1:0];
    c_we = 1'b0; c_wa = k_r; c_wd = {a_id_r, b_id_r}; c_re = 1'b0; c_ra = w_k;
    s_we = 1'b0; s_wa = sp_r; s_wd = {c_rd[NW-1:0], nl, c1}; s_re = 1'b0; s_ra = sp_m1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load && !stat.full) begin
      t_we       = 1'b1;
      cur_id_nxt = NW'(cnt_r);
      cur_w_nxt  = WW'(in_frequency);
      pos_nxt    = cnt_r[AW-1:0];
      cnt_nxt    = cnt_r + CW'(1);
    end
    if (cmd.su_step) begin
      if (stat.pos_zero) begin
        h_we = 1'b1;
      end else begin
        h_re = 1'b1;
        h_ra = parent;
      end
    end
    if (cmd.su_cmp) begin
      // The hole moves up: the parent drops into it, or the new entry settles.
      h_we = 1'b1;
      if (stat.su_swap) begin
        h_wd    = h_rd;
        pos_nxt = parent;
      end
    end
    if (cmd.pop_rd0 || cmd.walk_rd) begin
      h_re = 1'b1;
      h_ra = '0;
    end
    if (cmd.pop_rdl) begin
      if (cmd.sel_b) begin
        b_id_nxt = h_rd_id; b_w_nxt = h_rd_w;
      end else begin
        a_id_nxt = h_rd_id; a_w_nxt = h_rd_w;
      end
      h_re = 1'b1;
      h_ra = cnt_m1[AW-1:0];
    end
    if (cmd.pop_last) begin
      cur_id_nxt = h_rd_id;
      cur_w_nxt  = h_rd_w;
      cnt_nxt    = cnt_m1;
      pos_nxt    = '0;
    end
    if (cmd.sd_start) begin
      if (has_l) begin
        h_re = 1'b1;
        h_ra = lft_x[AW-1:0];
      end else begin
        h_we = 1'b1;
      end
    end
    if (cmd.sd_getl) begin
      l_id_nxt = h_rd_id;
      l_w_nxt  = h_rd_w;
      if (has_r) begin
        h_re = 1'b1;
        h_ra = rgt_x[AW-1:0];
      end
    end
    if (cmd.sd_cmp) begin
      h_we = 1'b1;
      if (stat.sd_swap) begin
        h_wd    = {m_id, m_w};
        pos_nxt = m_idx;
      end
    end
    if (cmd.merge) begin
      c_we       = 1'b1;
      cur_id_nxt = NW'(MAX_SYMBOLS) + NW'(k_r);
      cur_w_nxt  = a_w_r + b_w_r;
      pos_nxt    = cnt_r[AW-1:0];
      cnt_nxt    = cnt_r + CW'(1);
      k_nxt      = k_r + AW'(1);
    end
    if (cmd.walk_root) begin
      w_id_nxt   = h_rd_id;
      w_len_nxt  = '0;
      w_code_nxt = '0;
      sp_nxt     = '0;
    end
    if (cmd.w_node) begin
      if (stat.is_leaf) begin
        t_re = 1'b1;
      end else begin
        c_re = 1'b1;
      end
    end
    if (cmd.w_kids) begin
      // The one branch waits on the stack while the zero branch is walked.
      s_we       = 1'b1;
      sp_nxt     = sp_r + CW'(1);
      w_id_nxt   = c_rd[2*NW-1:NW];
      w_len_nxt  = nl;
      w_code_nxt = c0;
    end
    if (cmd.w_tag) begin
      out_valid_nxt = 1'b1;
      o_tag_nxt     = t_rd;
      o_len_nxt     = w_len_r;
      o_code_nxt    = w_code_r;
      o_last_nxt    = stat.sp_zero;
      if (!stat.sp_zero) begin
        s_re   = 1'b1;
        sp_nxt = sp_m1;
      end
    end
    if (cmd.w_pop) begin
      {w_id_nxt, w_len_nxt, w_code_nxt} = s_rd;
    end
    if (cmd.finish) begin
      cnt_nxt = '0;
      k_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_id_r <= cur_id_nxt;
    cur_w_r  <= cur_w_nxt;
    a_id_r   <= a_id_nxt;
    a_w_r    <= a_w_nxt;
    b_id_r   <= b_id_nxt;
    b_w_r    <= b_w_nxt;
    l_id_r   <= l_id_nxt;
    l_w_r    <= l_w_nxt;
    w_id_r   <= w_id_nxt;
    w_len_r  <= w_len_nxt;
    w_code_r <= w_code_nxt;
    o_tag_r  <= o_tag_nxt;
    o_len_r  <= o_len_nxt;
    o_code_r <= o_code_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tag         = o_tag_r;
  assign out_code_length = o_len_r;
  assign out_code_bits   = o_code_r;
  assign out_last_code   = o_last_r;

endmodule

// ===== rtl/huffman_code_builder_top.sv =====
// Loading a symbol sifts it up the heap level by level until it settles or reaches the root.
// After the final symbol, each merge costs a build step, two extractions (each sifting the
// last entry down from the root level by level), a merge step and a sift-up, all through the
// heap memory, which has one read port and one write port.
// Codes then leave one by one on a path walk of the tree; one set is in flight at a time.
// Reset is synchronous and active low; the memories need no clearing pass.
`include "huffman_code_builder_top_macros.svh"
module huffman_code_builder_top #(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hcb_pkg::TAG_W-1:0]  in_symbol_tag,
  input  logic [hcb_pkg::FREQ_W-1:0] in_frequency,
  input  logic                       in_final_symbol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcb_pkg::TAG_W-1:0]  out_tag,
  output logic [hcb_pkg::LEN_W-1:0]  out_code_length,
  output logic [hcb_pkg::CODE_W-1:0] out_code_bits,
  output logic                       out_last_code
);

  hcb_pkg::hcb_cmd_t  cmd;
  hcb_pkg::hcb_stat_t stat;

  hcb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_final_symbol(in_final_symbol), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_symbol_tag(in_symbol_tag), .in_frequency(in_frequency),
    .out_stall(out_stall), .out_valid(out_valid), .out_tag(out_tag),
    .out_code_length(out_code_length), .out_code_bits(out_code_bits),
    .out_last_code(out_last_code)
  );

  `HCB_ASSERT_IMPLY(a_tag_leaf, clk, rst_n, cmd.w_tag, stat.is_leaf && stat.out_free, "code from non-leaf")
  `HCB_ASSERT_IMPLY(a_kids_inner, clk, rst_n, cmd.w_kids, !stat.is_leaf, "leaf expanded as inner node")
  `HCB_ASSERT_IMPLY(a_merge_room, clk, rst_n, cmd.merge, !stat.full, "merge into full heap")
  `HCB_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load && !stat.full, in_stall, "second symbol taken during sift")

endmodule
